// File: rtl/fixed_block_allocator_macros.svh
// ----------------------------------------------------------------------------
// Fixed block allocator assertion macros
// Shared assertion forms, clocked on clk and quiet while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef FIXED_BLOCK_ALLOCATOR_MACROS_SVH
`define FIXED_BLOCK_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define FBA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define FBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/fba_pkg.sv
// ----------------------------------------------------------------------------
// Fixed block allocator package
// Pool geometry, status codes, item structs and cell control struct.
// ----------------------------------------------------------------------------
package fba_pkg;

  localparam int INDEX_BITS = 8;
  localparam int NUM_BLOCKS = 1 << INDEX_BITS;
  localparam int COUNT_W    = INDEX_BITS + 1;

  typedef logic [INDEX_BITS-1:0] idx_t;
  typedef logic [COUNT_W-1:0]    count_t;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_EXHAUSTED  = 3'd1;
  localparam logic [2:0] ST_FOREIGN    = 3'd2;
  localparam logic [2:0] ST_RANGE      = 3'd3;
  localparam logic [2:0] ST_MISALIGNED = 3'd4;
  localparam logic [2:0] ST_DOUBLE     = 3'd5;

  typedef struct packed {
    logic        op;
    logic [31:0] offset;
    logic        same_pool;
  } fba_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] block_offset;
    logic [7:0]  block_index;
  } fba_out_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic map_set;
    logic map_clr;
    idx_t sel;
  } fba_ctl_t;

endpackage

// File: rtl/fixed_block_allocator.sv
// ----------------------------------------------------------------------------
// Fixed block allocator
// Pool of equal power-of-two blocks with a LIFO free stack and a free bitmap.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: present in_data and raise start; the item is taken at a
//   clock edge where busy is low. op selects allocate or free; a free carries
//   the block's byte offset and the same_pool flag.
//   Result channel: out_valid pulses for one cycle with out_data (status,
//   byte offset and index). There is no backpressure on this side.
//   Configuration: cfg_data holds the block shift (log2 of the block size); a
//   write lands when cfg_valid is high, cfg_ready is always high. Write only
//   while no item is in flight.
//   The result is registered and appears in the cycle after accept, one item per cycle. The
//   free stack is a row of 2^INDEX_BITS shifting cells with cell 0 as the
//   top, so a pop or push is one shift of the row and the bitmap lookup is a
//   match in every cell, both within the accept cycle.
//   Reset (rst_n low, synchronous) loads stack cell k with the index
//   2^INDEX_BITS-1-k, marks every block free, sets the block shift to 12 and
//   holds busy high until the first cycle after reset.
// ----------------------------------------------------------------------------
`include "fixed_block_allocator_macros.svh"

module fixed_block_allocator import fba_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  fba_in_t    in_data,
  output logic       out_valid,
  output fba_out_t   out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [4:0] cfg_data
);

  logic [4:0] blk_shift_r, blk_shift_nxt;
  count_t     count_r, count_nxt;
  logic       busy_r;
  logic       out_valid_r, out_valid_nxt;
  fba_out_t   out_r, out_nxt;

  idx_t       entries [NUM_BLOCKS];
  logic [NUM_BLOCKS-1:0] hits;
  fba_ctl_t   ctl;

  logic        accept, is_alloc, empty, full;
  logic        in_range, aligned, map_hit;
  logic        alloc_ok, free_ok;
  logic [31:0] shifted, align_mask;
  idx_t        free_idx, top_idx;
  logic [31:0] free_idx_ext, top_idx_ext;

  // row of stack cells, cell 0 is the top of the stack
  for (genvar k = 0; k < NUM_BLOCKS; k++) begin : g_cell
    idx_t up_w, down_w;
    if (k == 0) begin : g_top
      assign up_w = free_idx;
    end else begin : g_mid
      assign up_w = entries[k-1];
    end
    if (k == NUM_BLOCKS - 1) begin : g_bot
      assign down_w = entries[k];
    end else begin : g_inner
      assign down_w = entries[k+1];
    end
    fba_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cell_id   (idx_t'(k)),
      .rst_entry (idx_t'(NUM_BLOCKS - 1 - k)),
      .ctl       (ctl),
      .from_up   (up_w),
      .from_down (down_w),
      .entry     (entries[k]),
      .free_hit  (hits[k])
    );
  end

  assign accept   = start && !busy_r;
  assign is_alloc = (in_data.op == OP_ALLOC);
  assign empty    = (count_r == '0);
  assign full     = (count_r == count_t'(NUM_BLOCKS));

  assign shifted    = in_data.offset >> blk_shift_r;
  assign in_range   = ((shifted >> INDEX_BITS) == 32'd0);
  assign align_mask = ~(32'hFFFF_FFFF << blk_shift_r);
  assign aligned    = ((in_data.offset & align_mask) == 32'd0);
  assign free_idx   = shifted[INDEX_BITS-1:0];
  assign top_idx    = entries[0];
  assign map_hit    = |hits;

  assign free_idx_ext = 32'(free_idx);
  assign top_idx_ext  = 32'(top_idx);

  assign alloc_ok = accept && is_alloc && !empty;
  assign free_ok  = accept && !is_alloc && in_data.same_pool && in_range && aligned
                    && !map_hit;

  always_comb begin
    ctl.sel     = is_alloc ? top_idx : free_idx;
    ctl.pop     = alloc_ok;
    ctl.map_clr = alloc_ok;
    ctl.map_set = free_ok;
    // drop the push on a full stack, the bit is still set
    ctl.push    = free_ok && !full;
  end

  always_comb begin
    count_nxt = count_r;
    if (alloc_ok) begin
      count_nxt = count_r - count_t'(1);
    end else if (free_ok && !full) begin
      count_nxt = count_r + count_t'(1);
    end
  end

  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = accept;
    if (accept) begin
      out_nxt.status       = ST_OK;
      out_nxt.block_offset = 32'd0;
      out_nxt.block_index  = 8'd0;
      if (is_alloc) begin
        if (empty) begin
          out_nxt.status = ST_EXHAUSTED;
        end else begin
          out_nxt.block_offset = top_idx_ext << blk_shift_r;
          out_nxt.block_index  = top_idx_ext[7:0];
        end
      end else if (!in_data.same_pool) begin
        out_nxt.status = ST_FOREIGN;
      end else if (!in_range) begin
        out_nxt.status = ST_RANGE;
      end else if (!aligned) begin
        out_nxt.status = ST_MISALIGNED;
      end else begin
        out_nxt.block_index = free_idx_ext[7:0];
        if (map_hit) begin
          out_nxt.status = ST_DOUBLE;
        end
      end
    end
  end

  assign blk_shift_nxt = cfg_valid ? cfg_data : blk_shift_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blk_shift_r <= 5'd12;
      count_r     <= count_t'(NUM_BLOCKS);
      busy_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      blk_shift_r <= blk_shift_nxt;
      count_r     <= count_nxt;
      busy_r      <= 1'b0;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;

  `FBA_ASSERT_NEXT(a_result_follows, start && !busy, out_valid, "accepted item gave no result")
  `FBA_ASSERT_NOW(a_count_bound, 1'b1, count_r <= count_t'(NUM_BLOCKS), "free count above pool size")
  `FBA_ASSERT_NEXT(a_alloc_pops, alloc_ok, count_r == count_t'($past(count_r) - count_t'(1)), "allocate did not pop the stack")
  `FBA_ASSERT_NOW(a_err_no_offset, out_valid && out_data.status != ST_OK, out_data.block_offset == 32'd0, "failed request carries an offset")

endmodule

// File: rtl/fba_cell.sv
// ----------------------------------------------------------------------------
// Fixed block allocator cell
// One slot of the shifting free stack plus the free bit of one block.
// ----------------------------------------------------------------------------
module fba_cell import fba_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  idx_t     cell_id,
  input  idx_t     rst_entry,
  input  fba_ctl_t ctl,
  input  idx_t     from_up,
  input  idx_t     from_down,
  output idx_t     entry,
  output logic     free_hit
);

  idx_t entry_r, entry_nxt;
  logic map_r, map_nxt;
  logic sel_me;

  assign sel_me = (ctl.sel == cell_id);

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.push) begin
      entry_nxt = from_up;
    end else if (ctl.pop) begin
      entry_nxt = from_down;
    end
  end

  always_comb begin
    map_nxt = map_r;
    if (ctl.map_set && sel_me) begin
      map_nxt = 1'b1;
    end else if (ctl.map_clr && sel_me) begin
      map_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r <= rst_entry;
      map_r   <= 1'b1;
    end else begin
      entry_r <= entry_nxt;
      map_r   <= map_nxt;
    end
  end

  assign entry    = entry_r;
  assign free_hit = map_r & sel_me;

endmodule

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// Fixed block allocator testbench
// Drives allocate and free requests through the start/busy port and predicts
// each status, byte offset and index with a local free stack and bitmap.
// Runs a directed opening and then random phases over several block sizes.
// Every result is compared field by field, in order.
// ----------------------------------------------------------------------------
module tb;
  import fba_pkg::*;

  localparam int SETTLE_CYCLES = 2;
  localparam int STALL_LIMIT   = 2000;
  localparam int RANDOM_REQS   = 500;
  localparam int PHASES        = 6;

  typedef enum logic [1:0] {REQ_ITEM, REQ_SET_SHIFT, REQ_DRAIN} req_kind_e;

  typedef struct {
    req_kind_e  kind;
    fba_in_t    item;
    logic [4:0] shift;
    bit         burst;
  } pool_req_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  fba_in_t    in_data = '0;
  logic       out_valid;
  fba_out_t   out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [4:0] cfg_data = '0;

  fixed_block_allocator u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 0;
  end

  // Local copy of the pool: stack of free indices, free bitmap, block size
  idx_t       avail_stack [NUM_BLOCKS];
  int         avail_count;
  bit         block_free [NUM_BLOCKS];
  logic [4:0] pool_shift;

  pool_req_t  req_queue [$];
  fba_out_t   pending_responses [$];

  int n_sent = 0;
  int n_results = 0;
  int error_count = 0;
  int cfg_writes = 0;
  int drains_done = 0;
  int status_seen [6] = '{default: 0};

  function automatic fba_out_t pool_response(fba_in_t req);
    fba_out_t   r;
    logic [63:0] pool_bytes;
    logic [63:0] low_mask;
    logic [63:0] off;
    idx_t       idx;
    r = '0;
    if (req.op == OP_ALLOC) begin
      if (avail_count == 0) begin
        r.status = ST_EXHAUSTED;
      end else begin
        avail_count--;
        idx = avail_stack[avail_count];
        block_free[idx] = 1'b0;
        r.status = ST_OK;
        r.block_offset = 32'(64'(idx) << pool_shift);
        r.block_index = idx;
      end
    end else begin
      pool_bytes = 64'(NUM_BLOCKS) << pool_shift;
      low_mask = (64'd1 << pool_shift) - 64'd1;
      off = {32'd0, req.offset};
      if (!req.same_pool) begin
        r.status = ST_FOREIGN;
      end else if (off >= pool_bytes) begin
        r.status = ST_RANGE;
      end else if ((off & low_mask) != 64'd0) begin
        r.status = ST_MISALIGNED;
      end else begin
        idx = idx_t'(off >> pool_shift);
        r.block_index = idx;
        if (block_free[idx]) begin
          r.status = ST_DOUBLE;
        end else begin
          block_free[idx] = 1'b1;
          // a full stack here would mean an inconsistent bitmap: drop the push
          if (avail_count < NUM_BLOCKS) begin
            avail_stack[avail_count] = idx;
            avail_count++;
          end
          r.status = ST_OK;
        end
      end
    end
    return r;
  endfunction

  task automatic queue_item(logic op, logic [31:0] offset, logic same, bit burst);
    pool_req_t r;
    r.kind = REQ_ITEM;
    r.item.op = op;
    r.item.offset = offset;
    r.item.same_pool = same;
    r.shift = '0;
    r.burst = burst;
    req_queue.insert(req_queue.size(), r);
  endtask

  task automatic queue_control(req_kind_e kind, logic [4:0] shift);
    pool_req_t r;
    r.kind = kind;
    r.item = '0;
    r.shift = shift;
    r.burst = 1'b0;
    req_queue.insert(req_queue.size(), r);
  endtask

  task automatic log_mismatch(string msg);
    error_count++;
    if (error_count <= 10) $display("MISMATCH: %s", msg);
  endtask

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    return $urandom_range(5, 25);
  endfunction

  // Driver
  int        gap_left = 0;
  int        idle_run = 0;
  bit        go;
  bit        cur_burst = 1'b0;
  pool_req_t head;

  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      cfg_valid <= 1'b0;
      gap_left = 0;
      idle_run = 0;
    end else begin
      go = start;
      if (start && !busy) begin
        pending_responses.insert(pending_responses.size(), pool_response(in_data));
        n_sent <= n_sent + 1;
        go = 1'b0;
        gap_left = cur_burst ? 0 : pick_gap();
      end
      if (cfg_valid && cfg_ready) begin
        pool_shift = cfg_data;
        cfg_writes++;
        cfg_valid <= 1'b0;
      end
      if (n_sent == n_results && !start && !cfg_valid) idle_run++;
      else idle_run = 0;
      // hold off new work while a register write is still on the port
      if (!go && !cfg_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (req_queue.size() > 0) begin
          head = req_queue[0];
          case (head.kind)
            REQ_ITEM: begin
              in_data <= head.item;
              cur_burst = head.burst;
              go = 1'b1;
              void'(req_queue.pop_front());
            end
            REQ_SET_SHIFT: begin
              if (idle_run > SETTLE_CYCLES) begin
                cfg_data <= head.shift;
                cfg_valid <= 1'b1;
                void'(req_queue.pop_front());
              end
            end
            default: begin
              if (idle_run > 0) begin
                drains_done++;
                void'(req_queue.pop_front());
              end
            end
          endcase
        end
      end
      start <= go;
    end
  end

  // Monitor
  fba_out_t want;

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (n_results >= n_sent) begin
        log_mismatch($sformatf("unexpected result status %0d offset %h index %0d",
                               out_data.status, out_data.block_offset,
                               out_data.block_index));
      end else begin
        want = pending_responses.pop_front();
        n_results <= n_results + 1;
        status_seen[want.status]++;
        if (out_data.status !== want.status
            || out_data.block_offset !== want.block_offset
            || out_data.block_index !== want.block_index) begin
          log_mismatch($sformatf(
            "result %0d: status %0d/%0d offset %h/%h index %0d/%0d (exp/got)",
            n_results, want.status, out_data.status, want.block_offset,
            out_data.block_offset, want.block_index, out_data.block_index));
        end
      end
    end
  end

  // Watchdog: cycles without any handshake
  int stall_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("Timeout after %0d idle cycles", stall_cycles);
        $display("CHECK FAILED");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    logic [4:0]  shift_plan [PHASES];
    int          alloc_pct [PHASES];
    logic [63:0] pool_bytes;
    logic [63:0] low_bits;
    logic [31:0] off;
    logic        same;
    bit          burst;
    int          roll;
    int          s;

    for (int i = 0; i < NUM_BLOCKS; i++) begin
      avail_stack[i] = idx_t'(i);
      block_free[i] = 1'b1;
    end
    avail_count = NUM_BLOCKS;
    pool_shift = 5'd12;

    // Directed opening at the reset block size of 4 KiB
    queue_item(OP_ALLOC, 32'h0, 1'b0, 1'b1);
    queue_item(OP_ALLOC, 32'hFFFF_FFFF, 1'b1, 1'b1);
    queue_item(OP_FREE, 32'h000F_F000, 1'b1, 1'b0);
    queue_item(OP_FREE, 32'h000F_F000, 1'b1, 1'b0);   // double free
    queue_item(OP_FREE, 32'h0, 1'b0, 1'b0);           // foreign
    queue_item(OP_FREE, 32'h0010_0000, 1'b1, 1'b1);   // exactly the pool size
    queue_item(OP_FREE, 32'hFFFF_FFFF, 1'b1, 1'b1);
    queue_item(OP_FREE, 32'h000F_E001, 1'b1, 1'b0);   // misaligned
    queue_item(OP_FREE, 32'h000F_E800, 1'b1, 1'b0);
    queue_item(OP_FREE, 32'h0, 1'b1, 1'b1);           // never allocated
    queue_item(OP_FREE, 32'hFFFF_FFFF, 1'b0, 1'b1);   // owner beats range
    queue_item(OP_FREE, 32'h0010_0001, 1'b1, 1'b0);   // range beats alignment
    queue_item(OP_FREE, 32'h000F_E000, 1'b1, 1'b0);
    queue_item(OP_ALLOC, 32'h1234_5678, 1'b1, 1'b1);  // LIFO reuse
    queue_item(OP_ALLOC, 32'h0, 1'b0, 1'b1);

    queue_control(REQ_SET_SHIFT, 5'd0);
    queue_item(OP_ALLOC, 32'h0, 1'b0, 1'b0);
    queue_item(OP_FREE, 32'd253, 1'b1, 1'b1);
    queue_item(OP_FREE, 32'd256, 1'b1, 1'b1);
    queue_item(OP_FREE, 32'd255, 1'b1, 1'b0);

    queue_control(REQ_SET_SHIFT, 5'd24);
    queue_item(OP_ALLOC, 32'h0, 1'b1, 1'b0);
    queue_item(OP_FREE, 32'hFFFF_FFFF, 1'b1, 1'b0);   // pool spans 4 GiB
    queue_item(OP_FREE, 32'h0100_0000, 1'b1, 1'b1);
    queue_item(OP_FREE, 32'hFF00_0000, 1'b1, 1'b1);

    // Block size beyond the nominal range: the offset wraps
    queue_control(REQ_SET_SHIFT, 5'd31);
    queue_item(OP_ALLOC, 32'h0, 1'b1, 1'b0);
    queue_item(OP_FREE, 32'h8000_0000, 1'b1, 1'b0);

    // Random phases: fill the pool, run it dry, then drain it again
    shift_plan = '{5'd0, 5'd24, 5'd31, 5'($urandom_range(1, 23)), 5'd26,
                   5'($urandom_range(0, 31))};
    alloc_pct = '{95, 95, 90, 85, 20, 50};
    for (int p = 0; p < PHASES; p++) begin
      queue_control(REQ_SET_SHIFT, shift_plan[p]);
      s = shift_plan[p];
      pool_bytes = 64'(NUM_BLOCKS) << s;
      low_bits = (64'd1 << s) - 64'd1;
      for (int k = 0; k < RANDOM_REQS / PHASES; k++) begin
        burst = (k % 40) < 12;
        if (k == 40) queue_control(REQ_DRAIN, '0);
        same = 1'b1;
        off = 32'(64'($urandom_range(0, NUM_BLOCKS - 1)) << s);
        roll = $urandom_range(0, 99);
        if (roll < alloc_pct[p]) begin
          queue_item(OP_ALLOC, $urandom, 1'($urandom_range(0, 1)), burst);
        end else begin
          roll = $urandom_range(0, 99);
          if (roll < 10 && s != 0) begin
            low_bits = 64'($urandom) & ((64'd1 << s) - 64'd1);
            off = off | 32'((low_bits == 64'd0) ? 64'd1 : low_bits);
          end else if (roll < 18 && pool_bytes <= 64'hFFFF_FFFF) begin
            off = (roll < 14) ? 32'(pool_bytes)
                              : $urandom_range(32'hFFFF_FFFF, 32'(pool_bytes));
          end else if (roll < 24) begin
            off = $urandom;
            same = 1'b0;
          end else if (roll < 30) begin
            off = $urandom;
            same = 1'($urandom_range(0, 1));
          end
          queue_item(OP_FREE, off, same, burst);
        end
      end
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk);
    while (req_queue.size() != 0 || start || cfg_valid || n_sent != n_results);
    repeat (4) @(negedge clk);

    if (pending_responses.size() != 0)
      log_mismatch($sformatf("%0d results never arrived", pending_responses.size()));

    $display("Ran %0d requests over %0d block sizes, %0d forced drains",
             n_sent, cfg_writes + 1, drains_done);
    $display("Statuses: ok %0d, exhausted %0d, foreign %0d, range %0d, misaligned %0d, double %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             status_seen[4], status_seen[5]);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("Mismatches: %0d", error_count);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
